@@ rtl/lowercase_path_string_hash_top_macros.svh @@
// Assertion macros for the lowercase path string hash block.
// Used by the checker; expects clk and arst_n in scope.
`ifndef LOWERCASE_PATH_STRING_HASH_TOP_MACROS_SVH
`define LOWERCASE_PATH_STRING_HASH_TOP_MACROS_SVH

// Clocked property, off while reset is held.
`define LPSH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define LPSH_ASSERT_IMP(lbl, ante, cons, msg) \
	`LPSH_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define LPSH_ASSERT_NXT(lbl, ante, cons, msg) \
	`LPSH_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ rtl/lpsh_pkg.sv @@
// Package for the lowercase path string hash block.
// Character constants and the byte fold, hash step and final mix functions.
package lpsh_pkg;

	localparam logic [7:0]  QUOTE_CH  = 8'h22;
	localparam logic [7:0]  BSLASH_CH = 8'h5c;
	localparam logic [7:0]  SLASH_CH  = 8'h2f;
	localparam logic [7:0]  NUL_CH    = 8'h00;
	localparam logic [7:0]  UPPER_OFS = 8'hbf;   // c + 0xbf maps 'A' to zero
	localparam logic [7:0]  UPPER_CNT = 8'h1a;
	localparam logic [7:0]  CASE_OFS  = 8'h20;
	localparam logic [31:0] HASH_MIN  = 32'd2;

	// Fold case and backslash, then sign-extend to 32 bits.
	function automatic logic [31:0] fold_extend(input logic [7:0] c);
		logic [7:0] f;
		logic [7:0] up;
		begin
			up = c + UPPER_OFS;
			if (up < UPPER_CNT) begin
				f = c + CASE_OFS;
			end else if (c == BSLASH_CH) begin
				f = SLASH_CH;
			end else begin
				f = c;
			end
			fold_extend = {{24{f[7]}}, f};
		end
	endfunction

	// One byte: add, times 0x401, xor with itself shifted right by 6.
	function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] c);
		logic [31:0] x;
		logic [31:0] y;
		begin
			x = h + fold_extend(c);
			y = x + (x << 10);
			hash_step = y ^ (y >> 6);
		end
	endfunction

	// Final mix: times 9, xor shift 11, times 0x8001, then 0 and 1 bumped up by 2.
	function automatic logic [31:0] finalize(input logic [31:0] h);
		logic [31:0] t;
		logic [31:0] u;
		logic [31:0] v;
		begin
			t = h + (h << 3);
			u = (t >> 11) ^ t;
			v = u + (u << 15);
			if (v < HASH_MIN) begin
				v = v + HASH_MIN;
			end
			finalize = v;
		end
	endfunction

endpackage

@@ rtl/lowercase_path_string_hash_top.sv @@
// A string's hash reaches the master side once its terminator transfer has passed the input
// register and the result register in turn, held back while a full result is not taken.
// Throughput: one byte per cycle save while a terminator is held back; the 32-bit running
// hash updates once per cycle in the single compute stage between input and result register.
// Reset (arst_n low, asynchronous): no string active, hash zero, both stages empty.
// Depends on lpsh_pkg.
module lowercase_path_string_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	// slave side: one string byte per transfer
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
	input  logic        s_axis_tuser,   // [0] start_req
	// master side: one hash per completed string
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [31:0] hash_value
);
	import lpsh_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        start_s1;

	// string state
	logic [31:0] hash_q;
	logic        quoted_q;
	logic        in_str_q;

	// result register
	logic        out_valid_q;
	logic [31:0] out_hash_q;

	// compute stage
	logic        is_quote;
	logic        active;       // byte belongs to a live string
	logic        open_quote;   // start byte that is an opening quote
	logic [31:0] base_hash;
	logic        base_quoted;
	logic        term;
	logic        emit;
	logic        out_free;
	logic        adv_s1;
	logic        in_xfer;

	assign is_quote    = (char_s1 == QUOTE_CH);
	assign active      = start_s1 | in_str_q;
	assign open_quote  = start_s1 & is_quote;
	// a start byte restarts from a clean hash, dropping any unfinished string
	assign base_hash   = start_s1 ? '0 : hash_q;
	assign base_quoted = start_s1 ? 1'b0 : quoted_q;
	assign term        = (char_s1 == NUL_CH) | (base_quoted & is_quote);
	assign emit        = valid_s1 & active & ~open_quote & term;

	// result register frees up when empty or being taken this cycle
	assign out_free = ~out_valid_q | m_axis_tready;
	// only a terminator byte can stall, and only on a full result register
	assign adv_s1   = valid_s1 & (~emit | out_free);

	assign s_axis_tready = ~valid_s1 | adv_s1;
	assign in_xfer       = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// string state: bytes outside a string leave it untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q   <= '0;
			quoted_q <= 1'b0;
			in_str_q <= 1'b0;
		end else if (adv_s1 && active) begin
			if (open_quote) begin
				hash_q   <= '0;
				quoted_q <= 1'b1;
				in_str_q <= 1'b1;
			end else if (term) begin
				hash_q   <= '0;
				quoted_q <= 1'b0;
				in_str_q <= 1'b0;
			end else begin
				hash_q   <= hash_step(base_hash, char_s1);
				quoted_q <= base_quoted;
				in_str_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && adv_s1) begin
			out_hash_q <= finalize(base_hash);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_hash_q;

endmodule

@@ rtl/lpsh_checker.sv @@
// Port-level checker for lowercase_path_string_hash_top, bound to the top level.
// Depends on lpsh_pkg and lowercase_path_string_hash_top_macros.svh.
`include "lowercase_path_string_hash_top_macros.svh"

module lpsh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	import lpsh_pkg::*;

	// stalled result holds
	`LPSH_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")

	// final mix never yields 0 or 1
	`LPSH_ASSERT_IMP(a_hash_floor, m_axis_tvalid, m_axis_tdata >= HASH_MIN, "hash below floor")

	// a fresh result is preceded by the input transfer that caused it
	`LPSH_ASSERT_IMP(a_out_cause, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without a causing transfer")

endmodule

bind lowercase_path_string_hash_top lpsh_checker u_lpsh_checker (.*);

@@ tb/sv/tb_lowercase_path_string_hash_top.sv @@
// Testbench for lowercase_path_string_hash_top: streams string bytes, predicts each hash
// with its own one-at-a-time model and checks every hash transfer on the master side.
// Depends on lpsh_pkg and the lowercase_path_string_hash_top RTL.
`timescale 1ns / 1ps

module tb_lowercase_path_string_hash_top;
	import lpsh_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off for backpressure
	localparam int DRAIN_CYCLES   = 8;     // wait after the expected-hash queue empties

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] char_byte
	logic        s_axis_tuser;   // [0] start_req
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;   // [31:0] hash_value

	// Predictor state: mirrors the block's running hash and string flags.
	logic [31:0] str_hash;
	bit          str_active;
	bit          str_quoted;
	logic [31:0] hash_q[$];      // expected hashes, oldest first

	int          errors;
	int          items_sent;
	int          quiet_cycles;
	int          send_idle_pct;  // chance per cycle that the sender idles
	int          rx_stall_pct;   // chance per cycle that the receiver stalls
	bit          rx_hold;        // forces tready low during the long hold-off

	lowercase_path_string_hash_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// 'A'..'Z' to lower case, backslash to slash, then sign-extend.
	function automatic logic [31:0] fold_char(input logic [7:0] c);
		logic [7:0] f;
		f = c;
		if (c >= 8'h41 && c <= 8'h5a) begin
			f = c + 8'h20;
		end else if (c == BSLASH_CH) begin
			f = SLASH_CH;
		end
		return {{24{f[7]}}, f};
	endfunction

	function automatic logic [31:0] mix_byte(input logic [31:0] h, input logic [7:0] c);
		logic [31:0] x;
		x = (h + fold_char(c)) * 32'h401;
		return x ^ (x >> 6);
	endfunction

	// Final avalanche; zero and one are bumped up by two.
	function automatic logic [31:0] finish_hash(input logic [31:0] h);
		logic [31:0] t;
		t = h * 32'd9;
		t = ((t >> 11) ^ t) * 32'h8001;
		if (t < 32'd2) begin
			t = t + 32'd2;
		end
		return t;
	endfunction

	// Advance the predictor by one accepted byte; push a hash on a terminator.
	task automatic predict_byte(input logic [7:0] c, input bit st);
		if (st) begin
			// a start abandons whatever string was open
			str_hash   = '0;
			str_active = 1'b1;
			str_quoted = (c == QUOTE_CH);
			if (str_quoted) begin
				return;  // opening quote is not hashed
			end
		end else if (!str_active) begin
			return;  // stray byte between strings
		end
		if (c == NUL_CH || (str_quoted && c == QUOTE_CH)) begin
			hash_q.push_back(finish_hash(str_hash));
			str_hash   = '0;
			str_active = 1'b0;
			str_quoted = 1'b0;
		end else begin
			str_hash = mix_byte(str_hash, c);
		end
	endtask

	// ------------------------------------------------------------------
	// Slave-side driver
	// ------------------------------------------------------------------

	// Offers one byte and returns at the edge of its transfer with tvalid still high,
	// so a following call can keep the bus busy without a bubble.
	task automatic send_byte(input logic [7:0] c, input bit st);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tuser  <= st;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		predict_byte(c, st);
		items_sent++;
	endtask

	// String content: weighted toward upper case, backslash and high bytes.
	function automatic logic [7:0] rand_char();
		unique case ($urandom_range(7))
			0:       return 8'h41 + 8'($urandom_range(25));
			1:       return 8'h61 + 8'($urandom_range(25));
			2:       return BSLASH_CH;
			3:       return 8'($urandom_range(255, 128));
			4:       return 8'($urandom_range(255, 1));
			default: return 8'($urandom_range(126, 32));
		endcase
	endfunction

	// Mostly short strings, now and then a long one.
	function automatic int rand_len();
		if ($urandom_range(19) == 0) begin
			return $urandom_range(48, 20);
		end
		return $urandom_range(6);
	endfunction

	// One string; without a terminator it is left open for the next start to abandon.
	task automatic send_string(input bit quoted, input int len, input bit terminate);
		logic [7:0] term;
		if (quoted) begin
			send_byte(QUOTE_CH, 1'b1);
		end
		for (int i = 0; i < len; i++) begin
			send_byte(rand_char(), !quoted && i == 0);
		end
		if (terminate) begin
			// a quoted string may also be closed by NUL
			term = (quoted && $urandom_range(3) != 0) ? QUOTE_CH : NUL_CH;
			send_byte(term, !quoted && len == 0);
		end
	endtask

	// ------------------------------------------------------------------
	// Master side: receiver stalls, result checker, watchdog
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (rx_hold) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic note_error(input string msg);
		if (errors < 10) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
		errors++;
	endtask

	always @(posedge clk) begin : check_hashes
		logic [31:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (hash_q.size() == 0) begin
				note_error($sformatf("unexpected hash %08h", m_axis_tdata));
			end else begin
				want = hash_q.pop_front();
				if (m_axis_tdata !== want) begin
					note_error($sformatf("hash expected %08h, got %08h",
						want, m_axis_tdata));
				end
			end
		end
	end

	// Ends a hung run: counts cycles in which neither side makes a transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Bytes without a start right after reset: no string is open, nothing comes out.
	task automatic test_idle_bytes();
		send_byte(8'h61, 1'b0);
		send_byte(8'hff, 1'b0);
	endtask

	// Start on NUL, quote then NUL, quote then quote: each gives the hash of nothing.
	task automatic test_empty_strings();
		send_byte(NUL_CH, 1'b1);
		send_byte(QUOTE_CH, 1'b1);
		send_byte(NUL_CH, 1'b0);
		send_byte(QUOTE_CH, 1'b1);
		send_byte(QUOTE_CH, 1'b0);
	endtask

	// Letter range edges, backslash, sign-extension edges, then a stray byte after NUL.
	task automatic test_case_fold();
		send_byte(8'h41, 1'b1);   // 'A'
		send_byte(8'h5a, 1'b0);   // 'Z'
		send_byte(8'h40, 1'b0);   // '@', just below the range
		send_byte(8'h5b, 1'b0);   // '[', just above
		send_byte(BSLASH_CH, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(NUL_CH, 1'b0);
		send_byte(8'h7a, 1'b0);   // after the terminator: ignored
	endtask

	// Quoted string closed by a quote; a quote inside an unquoted string is hashed.
	task automatic test_quoted();
		send_byte(QUOTE_CH, 1'b1);
		send_byte(8'h50, 1'b0);
		send_byte(BSLASH_CH, 1'b0);
		send_byte(QUOTE_CH, 1'b0);
		send_byte(8'h61, 1'b1);
		send_byte(QUOTE_CH, 1'b0);
		send_byte(NUL_CH, 1'b0);
	endtask

	// Restarts mid-string, including a lone opening quote that gets abandoned.
	task automatic test_restart();
		send_byte(8'h71, 1'b1);
		send_byte(8'h72, 1'b0);
		send_byte(QUOTE_CH, 1'b1);
		send_byte(8'h73, 1'b1);
		send_byte(NUL_CH, 1'b0);
	endtask

	// Random strings with some noise: stray bytes and strings left open.
	task automatic test_random_strings(input int n, input int idle_pct, input int stall_pct);
		int target;
		int r;
		send_idle_pct = idle_pct;
		rx_stall_pct  = stall_pct;
		target        = items_sent + n;
		while (items_sent < target) begin
			r = $urandom_range(99);
			if (r < 6) begin
				repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
			end else if (r < 12) begin
				send_string(1'($urandom_range(1)), $urandom_range(6, 1), 1'b0);
			end else begin
				send_string(1'($urandom_range(1)), rand_len(), 1'b1);
			end
		end
	endtask

	// Receiver holds off for a long stretch while short strings keep coming,
	// so the two stages fill and tready on the slave side drops.
	task automatic test_backpressure();
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		fork
			begin
				@(negedge clk);
				rx_hold = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				@(negedge clk);
				rx_hold = 1'b0;
			end
			repeat (12) send_string(1'b0, $urandom_range(2), 1'b1);
		join
	endtask

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		arst_n        = 1'b0;
		rx_hold       = 1'b0;
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		errors        = 0;
		items_sent    = 0;
		str_hash      = '0;
		str_active    = 1'b0;
		str_quoted    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_bytes();
		test_empty_strings();
		test_case_fold();
		test_quoted();
		test_restart();
		test_random_strings(125, 0, 0);
		test_backpressure();
		test_random_strings(125, 75, 0);
		test_random_strings(125, 0, 75);
		test_random_strings(125, 16, 16);

		s_axis_tvalid <= 1'b0;
		while (hash_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && hash_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
